>>> rtl/core/itbd_pkg.sv
`timescale 1ns / 1ps

package itbd_pkg;

  localparam int RADIX_W   = 6;
  localparam int CHAR_W    = 7;
  localparam int RADIX_MIN = 2;
  localparam int RADIX_MAX = 36;
  localparam int RADIX_RST = 10;

  localparam logic [CHAR_W-1:0] CHAR_ZERO = 7'h30;  // '0'
  localparam logic [CHAR_W-1:0] CHAR_A    = 7'h41;  // 'A'

  // handshake between the sequencer and the serial divider
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

  function automatic logic [RADIX_W-1:0] eff_radix(input logic [RADIX_W-1:0] r);
    logic [RADIX_W-1:0] res;
    if (r < RADIX_W'(RADIX_MIN)) res = RADIX_W'(RADIX_MIN);
    else if (r > RADIX_W'(RADIX_MAX)) res = RADIX_W'(RADIX_MAX);
    else res = r;
    return res;
  endfunction

  function automatic logic [CHAR_W-1:0] digit_to_char(input logic [RADIX_W-1:0] d);
    logic [CHAR_W-1:0] dv;
    logic [CHAR_W-1:0] ch;
    dv = (d > RADIX_W'(RADIX_MAX - 1)) ? CHAR_W'(RADIX_MAX - 1) : {1'b0, d};
    if (dv < CHAR_W'(10)) ch = CHAR_ZERO + dv;
    else ch = CHAR_A - CHAR_W'(10) + dv;
    return ch;
  endfunction

endpackage

>>> rtl/core/itbd_ram.sv
`timescale 1ns / 1ps

module itbd_ram #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 64,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> rtl/core/itbd_div.sv
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle. The remainder never
// reaches the base, so it fits the radix width.
module itbd_div #(
  parameter int W = 64
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [W-1:0]                     dividend,
  input  logic [itbd_pkg::RADIX_W-1:0]     base,
  output logic [W-1:0]                     quotient,
  output logic [itbd_pkg::RADIX_W-1:0]     remainder,
  output itbd_pkg::div_status_t            status
);

  localparam int RW = itbd_pkg::RADIX_W;
  localparam int CW = $clog2(W);

  logic [W-1:0]  q_r, q_nxt;
  logic [RW-1:0] rem_r, rem_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;

  logic [RW:0]   trial;
  logic          ge;

  always_comb begin
    trial    = {rem_r, q_r[W-1]};
    ge       = trial >= {1'b0, base};
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      q_nxt    = dividend;
      rem_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      q_nxt   = {q_r[W-2:0], ge};
      rem_nxt = ge ? RW'(trial - {1'b0, base}) : trial[RW-1:0];
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CW'(W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
  end

  assign quotient    = q_r;
  assign remainder   = rem_r;
  assign status.busy = busy_r;
  assign status.done = done_r;

endmodule

>>> rtl/core/integer_to_base_digits_top.sv
`timescale 1ns / 1ps

// Converts a signed integer to ASCII digits in the programmed radix (2..36,
// out-of-range values saturate), one result per digit, most significant
// first; is_negative rides on every result and last_digit marks the final
// one. Zero yields a single '0'. Each digit comes from a bit-serial divider,
// and digits are buffered in a small RAM and read back through a read state
// and a load state per digit, the load waiting while the output is stalled.
// A new request is taken once the last digit has been handed to the output
// register. Only the low VALUE_WIDTH bits of in_number are used; at most
// MAX_DIGITS least significant digits are kept.
module integer_to_base_digits_top #(
  parameter int VALUE_WIDTH = 64,
  parameter int MAX_DIGITS  = 64
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic signed [63:0]               in_number,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [itbd_pkg::CHAR_W-1:0]      out_digit_char,
  output logic                             out_is_negative,
  output logic                             out_last_digit,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [itbd_pkg::RADIX_W-1:0]     cfg_radix
);

  localparam int RW   = itbd_pkg::RADIX_W;
  localparam int CHW  = itbd_pkg::CHAR_W;
  localparam int VW   = VALUE_WIDTH;
  localparam int AW   = $clog2(MAX_DIGITS);
  localparam int CNTW = $clog2(MAX_DIGITS + 1);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_DIV  = 4'b0010,
    ST_RD   = 4'b0100,
    ST_LD   = 4'b1000
  } state_t;

  state_t        state_r, state_nxt;
  logic [RW-1:0] radix_r, radix_nxt;
  logic [CNTW-1:0] count_r, count_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic          sign_r, sign_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic [CHW-1:0] out_char_r;
  logic          out_neg_r;
  logic          out_last_r;

  logic [VW-1:0] x_in;
  logic          x_sign;
  logic [VW-1:0] x_mag;

  logic          in_take;
  logic          out_take;
  logic          out_free;
  logic          out_load;

  logic          div_start;
  logic [VW-1:0] div_dividend;
  logic [VW-1:0] div_quot;
  logic [RW-1:0] div_rem;
  itbd_pkg::div_status_t div_stat;

  logic          wr_en;
  logic          rd_en;
  logic [RW-1:0] rd_data;

  assign x_in   = in_number[VW-1:0];
  assign x_sign = x_in[VW-1];
  // most negative value maps to 2^(VW-1), exact in VW unsigned bits
  assign x_mag  = x_sign ? (~x_in + {{(VW-1){1'b0}}, 1'b1}) : x_in;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_take  = out_valid_r && !out_stall;
  assign out_free  = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt    = state_r;
    radix_nxt    = radix_r;
    count_nxt    = count_r;
    rd_ptr_nxt   = rd_ptr_r;
    sign_nxt     = sign_r;
    div_start    = 1'b0;
    div_dividend = div_quot;
    wr_en        = 1'b0;
    rd_en        = 1'b0;
    out_load     = 1'b0;

    if (cfg_valid && cfg_ready) begin
      radix_nxt = cfg_radix;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          sign_nxt     = x_sign;
          count_nxt    = '0;
          div_start    = 1'b1;
          div_dividend = x_mag;
          state_nxt    = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_stat.done) begin
          wr_en     = 1'b1;
          count_nxt = count_r + 1'b1;
          // zero input still runs one divide and yields a single '0'
          if ((div_quot != '0) && (count_r < CNTW'(MAX_DIGITS - 1))) begin
            div_start = 1'b1;
          end else begin
            rd_ptr_nxt = count_r[AW-1:0];
            state_nxt  = ST_RD;
          end
        end
      end
      ST_RD: begin
        rd_en     = 1'b1;
        state_nxt = ST_LD;
      end
      ST_LD: begin
        if (out_free) begin
          out_load = 1'b1;
          if (rd_ptr_r == '0) begin
            state_nxt = ST_IDLE;
          end else begin
            rd_ptr_nxt = rd_ptr_r - 1'b1;
            state_nxt  = ST_RD;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) out_valid_nxt = 1'b1;
    else if (out_take) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      radix_r     <= RW'(itbd_pkg::RADIX_RST);
      count_r     <= '0;
      rd_ptr_r    <= '0;
      sign_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      radix_r     <= radix_nxt;
      count_r     <= count_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      sign_r      <= sign_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_char_r <= itbd_pkg::digit_to_char(rd_data);
      out_neg_r  <= sign_r;
      out_last_r <= (rd_ptr_r == '0);
    end
  end

  itbd_div #(
    .W (VW)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dividend),
    .base      (itbd_pkg::eff_radix(radix_r)),
    .quotient  (div_quot),
    .remainder (div_rem),
    .status    (div_stat)
  );

  itbd_ram #(
    .WIDTH (RW),
    .DEPTH (MAX_DIGITS)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count_r[AW-1:0]),
    .wr_data (div_rem),
    .rd_en   (rd_en),
    .rd_addr (rd_ptr_r),
    .rd_data (rd_data)
  );

  assign out_valid       = out_valid_r;
  assign out_digit_char  = out_char_r;
  assign out_is_negative = out_neg_r;
  assign out_last_digit  = out_last_r;

`ifndef ASSERT_OFF
  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.done |-> state_r == ST_DIV)
    else $error("divider finished outside the divide phase");

  a_idle_div_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> !div_stat.busy)
    else $error("divider busy while idle");

  a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNTW'(MAX_DIGITS))
    else $error("digit count beyond store depth");

  a_read_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_RD |-> (count_r != '0) && (CNTW'(rd_ptr_r) < count_r))
    else $error("readback pointer outside stored digits");

  a_last_ends_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_load && (rd_ptr_r == '0) |=> state_r == ST_IDLE)
    else $error("last digit loaded without returning to idle");
`endif

endmodule
